[rtl/core/sta_pkg.sv]
// Shared constants, types and rounding helpers for the spatial transform unit.
package sta_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    localparam int ROW_W   = 3 * COMP_WIDTH;
    localparam int DATA_W  = ((6 * COMP_WIDTH + 7) / 8) * 8;
    localparam int PROD_W  = 2 * COMP_WIDTH;
    localparam int CROSS_W = PROD_W + 1;
    localparam int ACC1_W  = ((PROD_W + 2 > COMP_WIDTH + FRAC_BITS) ?
                              PROD_W + 2 : COMP_WIDTH + FRAC_BITS) + 1;
    localparam int XV_W    = (PROD_W + 3 - FRAC_BITS > COMP_WIDTH + 2) ?
                             PROD_W + 3 - FRAC_BITS : COMP_WIDTH + 2;
    localparam int PROD2_W = COMP_WIDTH + XV_W;
    localparam int ACC2_W  = PROD2_W + 3;
    localparam int FULL_W  = (ACC2_W > ACC1_W) ? ACC2_W : ACC1_W;
    localparam int RND_W   = FULL_W + 1 - FRAC_BITS;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic        [ROW_W-1:0]      row_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic signed [ACC1_W-1:0]     acc1_t;
    typedef logic signed [XV_W-1:0]       xv_t;
    typedef logic signed [PROD2_W-1:0]    prod2_t;
    typedef logic signed [ACC2_W-1:0]     acc2_t;
    typedef logic signed [FULL_W-1:0]     full_t;
    typedef logic signed [RND_W-1:0]      rnd_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FWD,
        KIND_INV,
        KIND_PT
    } kind_t;

    localparam logic [2:0] OP_MOTION_FWD = 3'd0;
    localparam logic [2:0] OP_MOTION_INV = 3'd1;
    localparam logic [2:0] OP_FORCE_FWD  = 3'd2;
    localparam logic [2:0] OP_FORCE_INV  = 3'd3;
    localparam logic [2:0] OP_POINT      = 3'd4;

    localparam logic [1:0] CFG_ROT_ROW0 = 2'd0;
    localparam logic [1:0] CFG_ROT_ROW1 = 2'd1;
    localparam logic [1:0] CFG_ROT_ROW2 = 2'd2;
    localparam logic [1:0] CFG_OFFSET_P = 2'd3;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};
    // 1.0, or the largest positive value when 1.0 does not fit
    localparam comp_t UNIT = (FRAC_BITS >= COMP_WIDTH - 1) ? COMP_MAX
                                                           : comp_t'(1 << FRAC_BITS);
    localparam row_t ROW0_RST = {{(2*COMP_WIDTH){1'b0}}, UNIT};
    localparam row_t ROW1_RST = {{COMP_WIDTH{1'b0}}, UNIT, {COMP_WIDTH{1'b0}}};
    localparam row_t ROW2_RST = {UNIT, {(2*COMP_WIDTH){1'b0}}};

    localparam logic signed [FULL_W:0] HALF =
        {{(FULL_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // round half up: floor((x + half) / 2^F)
    function automatic rnd_t round_full(input full_t x);
        logic signed [FULL_W:0] b;
        b = $signed({x[FULL_W-1], x}) + HALF;
        return rnd_t'(b >>> FRAC_BITS);
    endfunction

    // returns {clipped, value}
    function automatic logic [COMP_WIDTH:0] round_sat(input full_t x);
        rnd_t  q;
        comp_t v;
        logic  clip;
        q    = round_full(x);
        clip = 1'b1;
        if (q > rnd_t'(COMP_MAX))
        begin
            v = COMP_MAX;
        end
        else if (q < rnd_t'(COMP_MIN))
        begin
            v = COMP_MIN;
        end
        else
        begin
            v    = comp_t'(q);
            clip = 1'b0;
        end
        return {clip, v};
    endfunction

endpackage

[rtl/core/spatial_transform_apply.sv]
// Spatial-vector transform unit: six-stage pipelined motion, force and point transform.
//
// Takes one word per cycle while s_tready is high and returns one result word per input
// word, in order. An accepted word moves through the stage registers from stage 1 to
// stage 6 and waits wherever the output side stalls. The path is two
// multiply/accumulate passes: stage 1 forms R*a (or R^T*a) and p x a products,
// stage 2 sums them, stage 3 rounds and forms the second operand, stage 4 runs the
// second set of products, stage 5 sums them, and stage 6 rounds, saturates and holds
// the result. Every stage has its own valid bit and loads whenever it is empty or the
// stage after it takes its word, so bubbles collapse and s_tready stays high while any
// stage is free. s_tuser carries the op code; m_tuser[0] flags a clipped output.
// Registers are written through cfg_we/cfg_addr/cfg_wdata and must only change while
// the pipeline is empty.
module spatial_transform_apply (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // ang_x, ang_y, ang_z, lin_x, lin_y, lin_z
    input  logic [sta_pkg::DATA_W-1:0]   s_tdata,
    // op
    input  logic [2:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // ang_out_x, ang_out_y, ang_out_z, lin_out_x, lin_out_y, lin_out_z
    output logic [sta_pkg::DATA_W-1:0]   m_tdata,
    // saturated
    output logic [0:0]                   m_tuser,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_addr,
    input  logic [sta_pkg::ROW_W-1:0]    cfg_wdata
);
    import sta_pkg::*;

    // configuration
    row_t  rot_reg [3];
    row_t  offset_reg;
    comp_t rmat [3][3];
    comp_t pvec [3];

    // pipeline control
    logic [5:0] valid_reg;
    logic [5:0] en;

    // stage 0 (input decode)
    kind_t  kind_next;
    logic   swap_next;
    comp_t  ang_in [3];
    comp_t  lin_in [3];
    comp_t  rot_in [3];
    comp_t  oth_in [3];
    comp_t  mat_in [3][3];
    prod_t  p1_next [3][3];
    prod_t  pa1_next [3];
    prod_t  pb1_next [3];

    // stage 1
    kind_t  kind1_reg;
    logic   swap1_reg;
    comp_t  oth1_reg [3];
    prod_t  p1_reg [3][3];
    prod_t  pa1_reg [3];
    prod_t  pb1_reg [3];
    acc1_t  ro_pre_next [3];
    cross_t cr_next [3];

    // stage 2
    kind_t  kind2_reg;
    logic   swap2_reg;
    comp_t  oth2_reg [3];
    acc1_t  ro_pre2_reg [3];
    cross_t cr2_reg [3];
    xv_t    ro_next [3];
    xv_t    mv_next [3];

    // stage 3
    kind_t  kind3_reg;
    logic   swap3_reg;
    acc1_t  ro_pre3_reg [3];
    xv_t    ro3_reg [3];
    xv_t    mv3_reg [3];
    comp_t  mat3 [3][3];
    prod2_t q_next [3][3];
    prod2_t pa2_next [3];
    prod2_t pb2_next [3];

    // stage 4
    kind_t  kind4_reg;
    logic   swap4_reg;
    acc1_t  ro_pre4_reg [3];
    prod2_t q4_reg [3][3];
    prod2_t pa4_reg [3];
    prod2_t pb4_reg [3];
    acc2_t  bo_next [3];

    // stage 5
    kind_t  kind5_reg;
    logic   swap5_reg;
    acc1_t  ro_pre5_reg [3];
    acc2_t  bo5_reg [3];

    // stage 6 (output)
    comp_t  ang_out_reg [3];
    comp_t  lin_out_reg [3];
    logic   sat_reg;
    comp_t  ang_out_next [3];
    comp_t  lin_out_next [3];
    logic   sat_next;
    logic [COMP_WIDTH:0] rs [3];
    logic [COMP_WIDTH:0] bs [3];

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= ROW0_RST;
            rot_reg[1] <= ROW1_RST;
            rot_reg[2] <= ROW2_RST;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ROT_ROW0: rot_reg[0] <= cfg_wdata;
                CFG_ROT_ROW1: rot_reg[1] <= cfg_wdata;
                CFG_ROT_ROW2: rot_reg[2] <= cfg_wdata;
                CFG_OFFSET_P: offset_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pvec[i] = comp_t'(offset_reg[i*COMP_WIDTH +: COMP_WIDTH]);
            for (int j = 0; j < 3; j++)
            begin
                rmat[i][j] = comp_t'(rot_reg[i][j*COMP_WIDTH +: COMP_WIDTH]);
            end
        end
    end

    // ---------------- pipeline control ----------------
    always_comb
    begin
        en[5] = !valid_reg[5] || m_tready;
        for (int k = 4; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < 6; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: decode, first products ----------------
    always_comb
    begin
        unique case (s_tuser)
            OP_MOTION_FWD, OP_FORCE_FWD: kind_next = KIND_FWD;
            OP_MOTION_INV, OP_FORCE_INV: kind_next = KIND_INV;
            OP_POINT:                    kind_next = KIND_PT;
            default:                     kind_next = KIND_NONE;
        endcase
        // force ops rotate the linear part and offset the angular part
        swap_next = (s_tuser == OP_FORCE_FWD) || (s_tuser == OP_FORCE_INV);
        for (int i = 0; i < 3; i++)
        begin
            ang_in[i] = comp_t'(s_tdata[i*COMP_WIDTH +: COMP_WIDTH]);
            lin_in[i] = comp_t'(s_tdata[(i+3)*COMP_WIDTH +: COMP_WIDTH]);
        end
        for (int i = 0; i < 3; i++)
        begin
            rot_in[i] = (swap_next || kind_next == KIND_PT) ? lin_in[i] : ang_in[i];
            oth_in[i] = swap_next ? ang_in[i] : lin_in[i];
            for (int j = 0; j < 3; j++)
            begin
                mat_in[i][j] = (kind_next == KIND_INV) ? rmat[j][i] : rmat[i][j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p1_next[i][j] = prod_t'(mat_in[i][j]) * prod_t'(rot_in[j]);
            end
            pa1_next[i] = prod_t'(pvec[(i+1)%3]) * prod_t'(rot_in[(i+2)%3]);
            pb1_next[i] = prod_t'(pvec[(i+2)%3]) * prod_t'(rot_in[(i+1)%3]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            kind1_reg <= kind_next;
            swap1_reg <= swap_next;
            oth1_reg  <= oth_in;
            p1_reg    <= p1_next;
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
        end
    end

    // ---------------- stage 2: sums ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ro_pre_next[i] = acc1_t'(p1_reg[i][0]) + acc1_t'(p1_reg[i][1])
                           + acc1_t'(p1_reg[i][2])
                           + ((kind1_reg == KIND_PT) ? (acc1_t'(pvec[i]) <<< FRAC_BITS)
                                                     : acc1_t'(0));
            cr_next[i] = cross_t'(pa1_reg[i]) - cross_t'(pb1_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            kind2_reg   <= kind1_reg;
            swap2_reg   <= swap1_reg;
            oth2_reg    <= oth1_reg;
            ro_pre2_reg <= ro_pre_next;
            cr2_reg     <= cr_next;
        end
    end

    // ---------------- stage 3: round, second operand ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ro_next[i] = xv_t'(round_full(full_t'(ro_pre2_reg[i])));
            // forward: base minus rounded p x rotation input; other kinds: other part as is
            mv_next[i] = (kind2_reg == KIND_FWD)
                       ? xv_t'(oth2_reg[i]) - xv_t'(round_full(full_t'(cr2_reg[i])))
                       : xv_t'(oth2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            kind3_reg   <= kind2_reg;
            swap3_reg   <= swap2_reg;
            ro_pre3_reg <= ro_pre2_reg;
            ro3_reg     <= ro_next;
            mv3_reg     <= mv_next;
        end
    end

    // ---------------- stage 4: second products ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mat3[i][j] = (kind3_reg == KIND_INV) ? rmat[j][i] : rmat[i][j];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q_next[i][j] = prod2_t'(mat3[i][j]) * prod2_t'(mv3_reg[j]);
            end
            // p x rounded rotated part, inverse ops only
            pa2_next[i] = (kind3_reg == KIND_INV)
                        ? prod2_t'(pvec[(i+1)%3]) * prod2_t'(ro3_reg[(i+2)%3])
                        : prod2_t'(0);
            pb2_next[i] = (kind3_reg == KIND_INV)
                        ? prod2_t'(pvec[(i+2)%3]) * prod2_t'(ro3_reg[(i+1)%3])
                        : prod2_t'(0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            kind4_reg   <= kind3_reg;
            swap4_reg   <= swap3_reg;
            ro_pre4_reg <= ro_pre3_reg;
            q4_reg      <= q_next;
            pa4_reg     <= pa2_next;
            pb4_reg     <= pb2_next;
        end
    end

    // ---------------- stage 5: second sums ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bo_next[i] = acc2_t'(q4_reg[i][0]) + acc2_t'(q4_reg[i][1])
                       + acc2_t'(q4_reg[i][2])
                       + acc2_t'(pa4_reg[i]) - acc2_t'(pb4_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            kind5_reg   <= kind4_reg;
            swap5_reg   <= swap4_reg;
            ro_pre5_reg <= ro_pre4_reg;
            bo5_reg     <= bo_next;
        end
    end

    // ---------------- stage 6: round, saturate, output word ----------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rs[i] = round_sat(full_t'(ro_pre5_reg[i]));
            bs[i] = round_sat(full_t'(bo5_reg[i]));
        end
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ang_out_next[i] = '0;
            lin_out_next[i] = '0;
        end
        unique case (kind5_reg)
            KIND_FWD, KIND_INV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ang_out_next[i] = swap5_reg ? comp_t'(bs[i][COMP_WIDTH-1:0])
                                                : comp_t'(rs[i][COMP_WIDTH-1:0]);
                    lin_out_next[i] = swap5_reg ? comp_t'(rs[i][COMP_WIDTH-1:0])
                                                : comp_t'(bs[i][COMP_WIDTH-1:0]);
                    sat_next = sat_next | rs[i][COMP_WIDTH] | bs[i][COMP_WIDTH];
                end
            end
            KIND_PT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lin_out_next[i] = comp_t'(rs[i][COMP_WIDTH-1:0]);
                    sat_next = sat_next | rs[i][COMP_WIDTH];
                end
            end
            KIND_NONE:
            begin
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            ang_out_reg <= ang_out_next;
            lin_out_reg <= lin_out_next;
            sat_reg     <= sat_next;
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < 3; i++)
        begin
            m_tdata[i*COMP_WIDTH +: COMP_WIDTH]     = ang_out_reg[i];
            m_tdata[(i+3)*COMP_WIDTH +: COMP_WIDTH] = lin_out_reg[i];
        end
        m_tuser[0] = sat_reg;
    end

endmodule

[verif/testbench.sv]
// Self-checking testbench for spatial_transform_apply: directed and random words with stalls.
module testbench;

    import sta_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_WAIT   = 20;

    typedef longint vec3_t [3];

    typedef struct {
        logic [2:0] op;
        comp_t      ang[3];
        comp_t      lin[3];
    } xf_item_t;

    typedef struct {
        comp_t ang[3];
        comp_t lin[3];
        logic  sat;
    } xf_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata = '0;
    logic [2:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DATA_W-1:0]   m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_addr = '0;
    logic [ROW_W-1:0]    cfg_wdata = '0;

    // local copy of the transform registers, sign-extended
    longint     rot_m [3][3];
    vec3_t      offs_v;

    xf_result_t predicted_words [$];
    xf_result_t want_word;
    bit         word_bad;
    int         mismatch_cnt = 0;
    int         words_checked = 0;
    int         stuck_cycles = 0;
    int         hold_left = 0;
    bit         src_idle_en = 1'b0;
    bit         sink_idle_en = 1'b0;
    logic       long_hold_req = 1'b0;

    spatial_transform_apply u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint round_q(input longint x);
        return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t o);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic void rot_apply(input vec3_t x, input bit transp, output vec3_t y);
        for (int i = 0; i < 3; i++)
        begin
            y[i] = 0;
            for (int j = 0; j < 3; j++)
                y[i] += (transp ? rot_m[j][i] : rot_m[i][j]) * x[j];
        end
    endfunction

    function automatic void store_reg(input logic [1:0] idx, input row_t val);
        for (int k = 0; k < 3; k++)
        begin
            if (idx == CFG_OFFSET_P)
                offs_v[k] = comp_t'(val[k*COMP_WIDTH +: COMP_WIDTH]);
            else
                rot_m[idx][k] = comp_t'(val[k*COMP_WIDTH +: COMP_WIDTH]);
        end
    endfunction

    function automatic xf_result_t transform_vec(input xf_item_t it);
        vec3_t      a, l, rot_in, base, rot_o, base_o, ang_o, lin_o, t, u, c;
        longint     v;
        bit         clip;
        bit         motion;
        xf_result_t res;
        clip   = 1'b0;
        motion = (it.op == OP_MOTION_FWD) || (it.op == OP_MOTION_INV);
        for (int i = 0; i < 3; i++)
        begin
            a[i]      = it.ang[i];
            l[i]      = it.lin[i];
            rot_in[i] = motion ? a[i] : l[i];
            base[i]   = motion ? l[i] : a[i];
            ang_o[i]  = 0;
            lin_o[i]  = 0;
        end
        unique case (it.op)
            OP_MOTION_FWD, OP_FORCE_FWD:
            begin
                cross3(offs_v, rot_in, t);
                for (int i = 0; i < 3; i++)
                    c[i] = base[i] - round_q(t[i]);
                rot_apply(rot_in, 1'b0, t);
                rot_apply(c, 1'b0, u);
                for (int i = 0; i < 3; i++)
                begin
                    rot_o[i]  = round_q(t[i]);
                    base_o[i] = round_q(u[i]);
                end
            end
            OP_MOTION_INV, OP_FORCE_INV:
            begin
                // the rotated part feeds the cross product before saturation
                rot_apply(rot_in, 1'b1, t);
                for (int i = 0; i < 3; i++)
                    rot_o[i] = round_q(t[i]);
                rot_apply(base, 1'b1, t);
                cross3(offs_v, rot_o, u);
                for (int i = 0; i < 3; i++)
                    base_o[i] = round_q(t[i] + u[i]);
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rot_o[i]  = 0;
                    base_o[i] = 0;
                end
            end
        endcase
        if (it.op == OP_POINT)
        begin
            rot_apply(l, 1'b0, t);
            for (int i = 0; i < 3; i++)
                lin_o[i] = round_q(t[i] + (offs_v[i] <<< FRAC_BITS));
        end
        else if (it.op <= OP_FORCE_INV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ang_o[i] = motion ? rot_o[i] : base_o[i];
                lin_o[i] = motion ? base_o[i] : rot_o[i];
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            v = (i < 3) ? ang_o[i] : lin_o[i-3];
            if (v > longint'(COMP_MAX))
            begin
                v    = COMP_MAX;
                clip = 1'b1;
            end
            else if (v < longint'(COMP_MIN))
            begin
                v    = COMP_MIN;
                clip = 1'b1;
            end
            if (i < 3)
                res.ang[i] = comp_t'(v);
            else
                res.lin[i-3] = comp_t'(v);
        end
        res.sat = clip;
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic xf_item_t mk_item(input logic [2:0] op,
                                         input comp_t a0, input comp_t a1, input comp_t a2,
                                         input comp_t l0, input comp_t l1, input comp_t l2);
        xf_item_t it;
        it.op     = op;
        it.ang[0] = a0;
        it.ang[1] = a1;
        it.ang[2] = a2;
        it.lin[0] = l0;
        it.lin[1] = l1;
        it.lin[2] = l2;
        return it;
    endfunction

    function automatic row_t pack3(input comp_t e0, input comp_t e1, input comp_t e2);
        return {e2, e1, e0};
    endfunction

    // mode 0: within +-1.0, mode 1: anything, otherwise corner values
    function automatic comp_t rand_entry(input int mode);
        int pick;
        if (mode == 0)
            return comp_t'(int'($urandom_range(0, 8192)) - 4096);
        if (mode == 1)
            return comp_t'($urandom);
        pick = $urandom_range(0, 4);
        if (pick == 0)
            return COMP_MAX;
        if (pick == 1)
            return COMP_MIN;
        if (pick == 2)
            return '0;
        return (pick == 3) ? UNIT : -UNIT;
    endfunction

    function automatic comp_t rand_comp();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return comp_t'(int'($urandom_range(0, 16384)) - 8192);
        if (pick < 17)
            return comp_t'($urandom);
        return rand_entry(2);
    endfunction

    function automatic xf_item_t rand_item();
        logic [2:0] op;
        op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        return mk_item(op, rand_comp(), rand_comp(), rand_comp(),
                       rand_comp(), rand_comp(), rand_comp());
    endfunction

    task automatic send_word(input xf_item_t it);
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.lin[2], it.lin[1], it.lin[0], it.ang[2], it.ang[1], it.ang[0]};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predicted_words.push_back(transform_vec(it));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input row_t val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        store_reg(idx, val);
    endtask

    task automatic set_transform(input row_t r0, input row_t r1, input row_t r2, input row_t p);
        wait_drained();
        write_reg(CFG_ROT_ROW0, r0);
        write_reg(CFG_ROT_ROW1, r1);
        write_reg(CFG_ROT_ROW2, r2);
        write_reg(CFG_OFFSET_P, p);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_identity_reset();
        send_word(mk_item(OP_MOTION_FWD, COMP_MAX, COMP_MAX, COMP_MAX,
                          COMP_MAX, COMP_MAX, COMP_MAX));
        send_word(mk_item(OP_MOTION_INV, COMP_MIN, COMP_MIN, COMP_MIN,
                          COMP_MIN, COMP_MIN, COMP_MIN));
        send_word(mk_item(OP_FORCE_FWD, COMP_MAX, COMP_MIN, '0, 1, -1, UNIT));
        send_word(mk_item(OP_FORCE_INV, COMP_MIN, COMP_MAX, -1, '0, UNIT, -UNIT));
        send_word(mk_item(OP_POINT, COMP_MAX, COMP_MIN, 7, COMP_MAX, COMP_MIN, -3));
        // unused codes answer with an all-zero word
        for (int op = 5; op < 8; op++)
            send_word(mk_item(3'(op), 1234, -5678, COMP_MAX, COMP_MIN, UNIT, -1));
    endtask

    task automatic test_saturating_config();
        set_transform(pack3(COMP_MAX, COMP_MAX, COMP_MAX), pack3(COMP_MAX, COMP_MAX, COMP_MAX),
                      pack3(COMP_MAX, COMP_MAX, COMP_MAX), pack3(COMP_MIN, COMP_MIN, COMP_MIN));
        for (int op = 0; op < 5; op++)
            send_word(mk_item(3'(op), COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, 1));
        set_transform(pack3(COMP_MIN, COMP_MIN, COMP_MIN), pack3(COMP_MIN, COMP_MIN, COMP_MIN),
                      pack3(COMP_MIN, COMP_MIN, COMP_MIN), pack3(COMP_MAX, COMP_MAX, COMP_MAX));
        for (int op = 0; op < 5; op++)
            send_word(mk_item(3'(op), COMP_MIN, COMP_MIN, COMP_MAX, COMP_MAX, COMP_MIN, -1));
    endtask

    // R = 0.5*I makes odd inputs land exactly on the rounding midpoint
    task automatic test_half_rounding();
        set_transform(pack3(2048, 0, 0), pack3(0, 2048, 0), pack3(0, 0, 2048), pack3(1, -1, 0));
        send_word(mk_item(OP_POINT, '0, '0, '0, 1, -1, 3));
        send_word(mk_item(OP_MOTION_FWD, 1, -1, 1, 3, -3, 1));
        send_word(mk_item(OP_MOTION_INV, 1, -1, 1, 3, -3, 1));
        send_word(mk_item(OP_FORCE_FWD, -3, 3, -1, 1, 1, -1));
        send_word(mk_item(OP_FORCE_INV, -3, 3, -1, 1, 1, -1));
    endtask

    task automatic test_random_transforms();
        int mode;
        for (int ph = 0; ph < 8; ph++)
        begin
            mode = (ph < 4) ? 0 : $urandom_range(0, 2);
            set_transform(pack3(rand_entry(mode), rand_entry(mode), rand_entry(mode)),
                          pack3(rand_entry(mode), rand_entry(mode), rand_entry(mode)),
                          pack3(rand_entry(mode), rand_entry(mode), rand_entry(mode)),
                          pack3(rand_entry(mode), rand_entry(mode), rand_entry(mode)));
            src_idle_en  = (ph != 0) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
            repeat (50) send_word(rand_item());
        end
    endtask

    // sink stops for a long stretch while words keep coming, so the pipe fills
    task automatic test_output_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        s_tvalid      <= 1'b0;
        long_hold_req <= 1'b1;
        @(posedge clk);
        long_hold_req <= 1'b0;
        repeat (40) send_word(rand_item());
    endtask

    task automatic test_steady_tail();
        set_transform(pack3(rand_entry(0), rand_entry(0), rand_entry(0)),
                      pack3(rand_entry(0), rand_entry(0), rand_entry(0)),
                      pack3(rand_entry(0), rand_entry(0), rand_entry(0)),
                      pack3(rand_entry(1), rand_entry(1), rand_entry(1)));
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (60) send_word(rand_item());
    endtask

    // ---------------------------------------------------------------- output side

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_checked++;
                if (predicted_words.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("word %0d arrived with nothing pending: data=%h flag=%b",
                                 words_checked, m_tdata, m_tuser);
                    mismatch_cnt++;
                end
                else
                begin
                    want_word = predicted_words.pop_front();
                    word_bad  = (m_tuser[0] !== want_word.sat);
                    for (int k = 0; k < 3; k++)
                    begin
                        if (m_tdata[k*COMP_WIDTH +: COMP_WIDTH] !== want_word.ang[k])
                            word_bad = 1'b1;
                        if (m_tdata[(k+3)*COMP_WIDTH +: COMP_WIDTH] !== want_word.lin[k])
                            word_bad = 1'b1;
                    end
                    if (word_bad)
                    begin
                        if (mismatch_cnt < 10)
                            $display("word %0d: expected data=%h flag=%b, got data=%h flag=%b",
                                     words_checked,
                                     {want_word.lin[2], want_word.lin[1], want_word.lin[0],
                                      want_word.ang[2], want_word.ang[1], want_word.ang[0]},
                                     want_word.sat, m_tdata, m_tuser);
                        mismatch_cnt++;
                    end
                end
            end
            if (long_hold_req)
                hold_left = LONG_HOLD;
            else if (hold_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 16);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        store_reg(CFG_ROT_ROW0, ROW0_RST);
        store_reg(CFG_ROT_ROW1, ROW1_RST);
        store_reg(CFG_ROT_ROW2, ROW2_RST);
        store_reg(CFG_OFFSET_P, '0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_identity_reset();
        test_saturating_config();
        test_half_rounding();
        test_random_transforms();
        test_output_backpressure();
        test_steady_tail();
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
